>>> hdl/coo_index_value_sorter_macros.svh
// Assertion macros for the COO entry sorter.
`ifndef COO_INDEX_VALUE_SORTER_MACROS_SVH
`define COO_INDEX_VALUE_SORTER_MACROS_SVH

// Plain property, checked on every clock outside reset.
`define CIVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CIVS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/civs_pkg.sv
// Shared types and constants of the COO entry sorter.
package civs_pkg;

    localparam int COORD_W         = 31;
    localparam int VALUE_W         = 64;
    localparam int NUM_COORDS      = 4;
    localparam int RANK_W          = 3;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int MAX_RANK_DEF    = 4;

    typedef struct packed {
        logic [COORD_W-1:0] coord_0;
        logic [COORD_W-1:0] coord_1;
        logic [COORD_W-1:0] coord_2;
        logic [COORD_W-1:0] coord_3;
        logic [VALUE_W-1:0] value_bits;
        logic               is_last;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] coord_0;
        logic [COORD_W-1:0] coord_1;
        logic [COORD_W-1:0] coord_2;
        logic [COORD_W-1:0] coord_3;
        logic [VALUE_W-1:0] value_bits;
    } entry_t;

    typedef struct packed {
        logic [COORD_W-1:0] sorted_coord_0;
        logic [COORD_W-1:0] sorted_coord_1;
        logic [COORD_W-1:0] sorted_coord_2;
        logic [COORD_W-1:0] sorted_coord_3;
        logic [VALUE_W-1:0] sorted_value;
        logic               final_entry;
        logic               overflowed;
    } result_t;

endpackage

>>> hdl/civs_front.sv
// Front end: input handshake, key rank register and a two-deep item queue.
module civs_front
    import civs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RANK_W-1:0] cfg_data,
    output logic [RANK_W-1:0] key_rank,
    output logic              fifo_valid,
    output item_t             fifo_item,
    input  logic              fifo_pop,
    input  logic              set_done
);

    item_t             fifo_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              pend_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              push;

    assign busy       = (cnt_reg == 2'd2) | pend_reg;
    assign push       = start & ~busy;
    assign fifo_valid = (cnt_reg != 2'd0);
    assign fifo_item  = fifo_reg[rd_ptr_reg];
    assign cfg_ready  = 1'b1;
    assign key_rank   = rank_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            pend_reg   <= 1'b0;
            rank_reg   <= RANK_W'(1);
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, fifo_pop};
            if (push && item.is_last)
            begin
                pend_reg <= 1'b1;
            end
            else if (set_done)
            begin
                pend_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                rank_reg <= cfg_data;
            end
        end
    end

endmodule

>>> hdl/civs_back.sv
// Back end: entry store, stable selection sort by repeated scans, result register.
`include "coo_index_value_sorter_macros.svh"
module civs_back
    import civs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_RANK    = MAX_RANK_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [RANK_W-1:0] key_rank,
    input  logic              fifo_valid,
    input  item_t             fifo_item,
    output logic              fifo_pop,
    output logic              set_done,
    output result_t           result,
    output logic              result_valid
);

    localparam int IDX_W    = $clog2(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W    = NUM_COORDS * COORD_W;
    localparam int TOP_RANK = (MAX_RANK < NUM_COORDS) ? MAX_RANK : NUM_COORDS;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FETCH = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              best_vld_reg, best_vld_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic              have_last_reg, have_last_next;
    logic [KEY_W-1:0]  last_key_reg, last_key_next;
    logic [IDX_W-1:0]  last_idx_reg, last_idx_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    result_t           result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic [RANK_W-1:0] rank_eff;
    logic [KEY_W-1:0]  cur_key;
    logic              issue;
    logic              is_cand;
    logic              is_fin;

    always_comb
    begin
        if (key_rank == '0)
        begin
            rank_eff = RANK_W'(1);
        end
        else if (key_rank > RANK_W'(TOP_RANK))
        begin
            rank_eff = RANK_W'(TOP_RANK);
        end
        else
        begin
            rank_eff = key_rank;
        end
    end

    assign cur_key = {rd_data_reg.coord_0,
                      (rank_eff > RANK_W'(1)) ? rd_data_reg.coord_1 : '0,
                      (rank_eff > RANK_W'(2)) ? rd_data_reg.coord_2 : '0,
                      (rank_eff > RANK_W'(3)) ? rd_data_reg.coord_3 : '0};

    assign issue   = (scan_reg < count_reg);
    assign is_cand = !have_last_reg || (cur_key > last_key_reg)
                     || ((cur_key == last_key_reg) && (cmp_idx_reg > last_idx_reg));
    assign is_fin  = (CNT_W'(emit_reg + 1'b1) == count_reg);

    assign fifo_pop     = (state_reg == S_LOAD) && fifo_valid;
    assign wr_en        = fifo_pop && (count_reg < CNT_W'(MAX_ENTRIES));
    assign rd_addr      = (state_reg == S_FETCH) ? best_idx_reg : scan_reg[IDX_W-1:0];
    assign set_done     = (state_reg == S_EMIT) && is_fin;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{coord_0:    fifo_item.coord_0,
                                           coord_1:    fifo_item.coord_1,
                                           coord_2:    fifo_item.coord_2,
                                           coord_3:    fifo_item.coord_3,
                                           value_bits: fifo_item.value_bits};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        drop_next         = drop_reg;
        scan_next         = scan_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = scan_reg[IDX_W-1:0];
        best_vld_next     = best_vld_reg;
        best_key_next     = best_key_reg;
        best_idx_next     = best_idx_reg;
        have_last_next    = have_last_reg;
        last_key_next     = last_key_reg;
        last_idx_next     = last_idx_reg;
        emit_next         = emit_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (fifo_pop)
                begin
                    if (wr_en)
                    begin
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (fifo_item.is_last)
                    begin
                        state_next     = S_SCAN;
                        scan_next      = '0;
                        best_vld_next  = 1'b0;
                        have_last_next = 1'b0;
                        emit_next      = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    cmp_vld_next = 1'b1;
                    scan_next    = CNT_W'(scan_reg + 1'b1);
                end
                if (cmp_vld_reg && is_cand && (!best_vld_reg || (cur_key < best_key_reg)))
                begin
                    best_vld_next = 1'b1;
                    best_key_next = cur_key;
                    best_idx_next = cmp_idx_reg;
                end
                if (!issue && !cmp_vld_reg)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                result_valid_next          = 1'b1;
                result_next.sorted_coord_0 = rd_data_reg.coord_0;
                result_next.sorted_coord_1 = rd_data_reg.coord_1;
                result_next.sorted_coord_2 = rd_data_reg.coord_2;
                result_next.sorted_coord_3 = rd_data_reg.coord_3;
                result_next.sorted_value   = rd_data_reg.value_bits;
                result_next.final_entry    = is_fin;
                result_next.overflowed     = drop_reg;
                have_last_next             = 1'b1;
                last_key_next              = best_key_reg;
                last_idx_next              = best_idx_reg;
                emit_next                  = CNT_W'(emit_reg + 1'b1);
                scan_next                  = '0;
                best_vld_next              = 1'b0;
                if (is_fin)
                begin
                    state_next = S_LOAD;
                    count_next = '0;
                    drop_next  = 1'b0;
                    emit_next  = '0;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        last_key_reg <= last_key_next;
        last_idx_reg <= last_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            drop_reg         <= 1'b0;
            scan_reg         <= '0;
            cmp_vld_reg      <= 1'b0;
            best_vld_reg     <= 1'b0;
            have_last_reg    <= 1'b0;
            emit_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            drop_reg         <= drop_next;
            scan_reg         <= scan_next;
            cmp_vld_reg      <= cmp_vld_next;
            best_vld_reg     <= best_vld_next;
            have_last_reg    <= have_last_next;
            emit_reg         <= emit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    `CIVS_ASSERT(a_count_range, count_reg <= CNT_W'(MAX_ENTRIES), "entry count above capacity")
    `CIVS_ASSERT_IMP(a_load_no_emit, state_reg == S_LOAD, emit_reg == '0, "emit count in load")
    `CIVS_ASSERT_IMP(a_final_to_load, result_valid_reg && result_reg.final_entry,
                     state_reg == S_LOAD, "final result while not loading")
    `CIVS_ASSERT_IMP(a_fetch_has_best, state_reg == S_FETCH, best_vld_reg,
                     "fetch without a selected entry")

endmodule

>>> hdl/coo_index_value_sorter.sv
// Top level of the COO entry sorter.
//
// Items enter on start/busy: an item transfers at a clock edge with start high
// and busy low. While busy is low, items load at one per cycle through a
// two-deep queue into the entry store. The item with is_last set closes the set;
// busy then stays high until the whole set has been sent.
// Each stored entry comes out once on result, marked by result_valid for one
// cycle, in ascending key order (ties in arrival order); the last one carries
// final_entry. The receiver cannot hold results off.
// Sorting scans the store once per result through the single store read port.
// key_rank is written over cfg_valid/cfg_ready (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
// Entries past MAX_ENTRIES are dropped and the set reports overflowed.
// Reset empties the set and sets key_rank to 1; no clearing pass is needed.
module coo_index_value_sorter
    import civs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int MAX_RANK    = MAX_RANK_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RANK_W-1:0] cfg_data,
    output result_t           result,
    output logic              result_valid
);

    logic [RANK_W-1:0] key_rank;
    logic              fifo_valid;
    item_t             fifo_item;
    logic              fifo_pop;
    logic              set_done;

    civs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .key_rank   (key_rank),
        .fifo_valid (fifo_valid),
        .fifo_item  (fifo_item),
        .fifo_pop   (fifo_pop),
        .set_done   (set_done)
    );

    civs_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_RANK    (MAX_RANK)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_rank     (key_rank),
        .fifo_valid   (fifo_valid),
        .fifo_item    (fifo_item),
        .fifo_pop     (fifo_pop),
        .set_done     (set_done),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
